[rtl/sha256_pkg.sv]
`default_nettype none

package sha256_pkg;

	typedef logic [31:0] word_t;

	// initial hash values
	localparam word_t [0:7] INIT_HASH = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// round constants
	localparam word_t [0:63] ROUND_K = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// byte position where the length field starts
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t small_s0(input word_t x);
		small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_s1(input word_t x);
		small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t big_s0(input word_t x);
		big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_s1(input word_t x);
		big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

`default_nettype wire

[rtl/sha256_message_digest.sv]
`default_nettype none

// SHA-256 over a byte stream with bit-granular message length. A beat is taken
// when start is high and busy is low. A non-final byte leaves busy low unless it
// completes a 64-byte block; that byte is followed by the 64 rounds through the
// single round unit and the hash update. A final beat then pushes the marker,
// zero padding and length one byte per cycle except while a block compresses
// (up to about 72 bytes, plus one or two block compressions) and emits the eight
// digest words on consecutive cycles, each marked by done for exactly one cycle;
// the receiver cannot stall them, so it must take every word when done is high.
module sha256_message_digest (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire  [7:0] data_byte,
	input  wire  [3:0] valid_bits,
	input  wire        last_item,
	output logic       done,
	output logic [31:0] digest_word,
	output logic [2:0] word_index,
	output logic       last_word
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_HADD = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [5:0] pos_q;
	logic [63:0] bits_q;
	logic [5:0] round_q;
	logic        final_q;
	logic        marker_q;
	logic        len_q;
	logic [2:0]  cnt_q;
	logic [23:0] cur_q;

	sha256_pkg::word_t hash_q [8];
	sha256_pkg::word_t work_q [8];
	sha256_pkg::word_t win_q [16];

	logic       accept;
	logic [3:0] nv;
	logic [7:0] final_byte;
	logic       push_en;
	logic [7:0] push_byte;
	logic       block_end;

	// round datapath
	sha256_pkg::word_t ch, maj, t1, t2, w_new;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// clamp the valid bit count and build the final byte
	always_comb begin
		nv = (valid_bits > 4'd8) ? 4'd8 : valid_bits;
		final_byte = (data_byte & ~(8'hFF >> nv)) | (8'h80 >> nv);
	end

	// byte push selection
	always_comb begin
		push_en = 1'b0;
		push_byte = 8'h00;
		case (state_q)
			ST_IDLE: begin
				push_en = accept;
				push_byte = (last_item && nv != 4'd8) ? final_byte : data_byte;
			end
			ST_PAD: begin
				push_en = 1'b1;
				if (marker_q) begin
					push_byte = 8'h80;
				end else if (len_q || pos_q == sha256_pkg::LEN_POS) begin
					push_byte = bits_q[63:56];
				end else begin
					push_byte = 8'h00;
				end
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
		block_end = push_en && (pos_q == 6'd63);
	end

	// one compression round
	always_comb begin
		ch = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
		maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
		t1 = work_q[7] + sha256_pkg::big_s1(work_q[4]) + ch
			+ sha256_pkg::ROUND_K[round_q] + win_q[0];
		t2 = sha256_pkg::big_s0(work_q[0]) + maj;
		w_new = sha256_pkg::small_s1(win_q[14]) + win_q[9]
			+ sha256_pkg::small_s0(win_q[1]) + win_q[0];
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			bits_q <= '0;
			round_q <= '0;
			final_q <= 1'b0;
			marker_q <= 1'b0;
			len_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_OUT);
			if (push_en) begin
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last_item) begin
							bits_q <= bits_q + {60'd0, nv};
							final_q <= 1'b1;
							marker_q <= (nv == 4'd8);
							state_q <= block_end ? ST_RND : ST_PAD;
						end else begin
							bits_q <= bits_q + 64'd8;
							if (block_end) begin
								state_q <= ST_RND;
							end
						end
					end
				end
				ST_PAD: begin
					if (marker_q) begin
						marker_q <= 1'b0;
					end else if (len_q || pos_q == sha256_pkg::LEN_POS) begin
						len_q <= 1'b1;
						bits_q <= {bits_q[55:0], 8'h00};
					end
					if (block_end) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) begin
						state_q <= ST_HADD;
					end
				end
				ST_HADD: begin
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else if (len_q) begin
						state_q <= ST_OUT;
						cnt_q <= '0;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						final_q <= 1'b0;
						len_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hash words: reset value, block update, output shift and reload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha256_pkg::INIT_HASH[i];
			end
		end else if (state_q == ST_HADD) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + work_q[i];
			end
		end else if (state_q == ST_OUT) begin
			if (cnt_q == 3'd7) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= sha256_pkg::INIT_HASH[i];
				end
			end else begin
				for (int i = 0; i < 7; i++) begin
					hash_q[i] <= hash_q[i + 1];
				end
			end
		end
	end

	// result beat registers
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			digest_word <= hash_q[0];
			word_index <= cnt_q;
			last_word <= (cnt_q == 3'd7);
		end
	end

	// byte assembly, message window and working variables
	always_ff @(posedge clk) begin
		if (push_en) begin
			cur_q <= {cur_q[15:0], push_byte};
			if (pos_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i + 1];
				end
				win_q[15] <= {cur_q, push_byte};
			end
		end else if (state_q == ST_RND) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
		end

		if (block_end) begin
			for (int i = 0; i < 8; i++) begin
				work_q[i] <= hash_q[i];
			end
		end else if (state_q == ST_RND) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;

	localparam int DIR_ROWS   = 18;
	localparam int RAND_BEATS = 170;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;
	localparam logic [3:0] FULL_BYTE = 4'd8;

	// well known digests of the empty message and of "abc"
	localparam logic [255:0] EMPTY_MSG_DIGEST =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] ABC_MSG_DIGEST =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	localparam sha256_pkg::word_t START_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam sha256_pkg::word_t RND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		sha256_pkg::word_t word;
		logic [2:0]        idx;
		logic              fin;
	} digest_exp_t;

	typedef struct packed {
		logic [7:0]   d;
		logic [3:0]   vb;
		logic         fin;
		logic         typed;
		logic [255:0] dg;
	} stim_row_t;

	// directed beats; digests typed in only for the well known messages
	stim_row_t dir_tab [DIR_ROWS] = '{
		'{8'h00, 4'd0,  1'b1, 1'b1, EMPTY_MSG_DIGEST},  // empty message
		'{8'h61, 4'd8,  1'b0, 1'b0, 256'd0},
		'{8'h62, 4'd8,  1'b0, 1'b0, 256'd0},
		'{8'h63, 4'd8,  1'b1, 1'b1, ABC_MSG_DIGEST},    // "abc"
		'{8'hff, 4'd1,  1'b1, 1'b0, 256'd0},            // single bit message
		'{8'hff, 4'd7,  1'b1, 1'b0, 256'd0},
		'{8'ha5, 4'd0,  1'b0, 1'b0, 256'd0},            // count ignored mid message
		'{8'h5a, 4'd15, 1'b0, 1'b0, 256'd0},
		'{8'h3c, 4'd9,  1'b1, 1'b0, 256'd0},            // count above 8 clamps
		'{8'h00, 4'd8,  1'b1, 1'b0, 256'd0},
		'{8'hff, 4'd8,  1'b0, 1'b0, 256'd0},
		'{8'hff, 4'd4,  1'b1, 1'b0, 256'd0},            // low bits cleared
		'{8'h81, 4'd3,  1'b1, 1'b0, 256'd0},
		'{8'h7e, 4'd8,  1'b0, 1'b0, 256'd0},
		'{8'hc3, 4'd0,  1'b1, 1'b0, 256'd0},            // empty final beat
		'{8'hff, 4'd15, 1'b1, 1'b0, 256'd0},
		'{8'h00, 4'd12, 1'b0, 1'b0, 256'd0},
		'{8'h01, 4'd8,  1'b1, 1'b0, 256'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  data_byte;
	logic [3:0]  valid_bits;
	logic        last_item;
	logic        done;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	// predictor state
	sha256_pkg::word_t hash_st [8];
	sha256_pkg::word_t win [16];
	logic [5:0]  fill_pos;
	logic [63:0] bit_total;

	digest_exp_t digest_q [$];
	int          beats_sent;
	int          msgs_done;
	int          words_seen;
	int          bad_words;
	int          longest_msg;
	int          msg_len;

	sha256_message_digest i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.data_byte   (data_byte),
		.valid_bits  (valid_bits),
		.last_item   (last_item),
		.done        (done),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always #10 clk = ~clk;

	function automatic sha256_pkg::word_t ror32(input sha256_pkg::word_t x,
			input int unsigned n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	// one block through the 64 rounds, folded into the running hash
	task automatic compress_window();
		sha256_pkg::word_t w [64];
		sha256_pkg::word_t v [8];
		sha256_pkg::word_t t1, t2;
		for (int j = 0; j < 16; j++)
			w[j] = win[j];
		for (int j = 16; j < 64; j++)
			w[j] = w[j-16] + w[j-7]
				+ (ror32(w[j-15], 7) ^ ror32(w[j-15], 18) ^ (w[j-15] >> 3))
				+ (ror32(w[j-2], 17) ^ ror32(w[j-2], 19) ^ (w[j-2] >> 10));
		for (int j = 0; j < 8; j++)
			v[j] = hash_st[j];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[r] + w[r];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			hash_st[j] = hash_st[j] + v[j];
	endtask

	// bytes shift into the window word, so four of them leave it big-endian
	task automatic take_byte(input logic [7:0] b);
		win[fill_pos[5:2]] = {win[fill_pos[5:2]][23:0], b};
		fill_pos = fill_pos + 6'd1;
		if (fill_pos == 6'd0)
			compress_window();
	endtask

	task automatic clear_hash();
		for (int j = 0; j < 8; j++)
			hash_st[j] = START_HASH[j];
		fill_pos = '0;
		bit_total = '0;
	endtask

	// advance the digest model by one accepted beat
	task automatic predict_digest(input logic [7:0] d, input logic [3:0] vb, input logic fin,
			input logic typed, input logic [255:0] typed_dg);
		logic [3:0] nv;
		logic [7:0] keep;
		nv = (vb > FULL_BYTE) ? FULL_BYTE : vb;
		if (!fin) begin
			take_byte(d);
			bit_total = bit_total + 64'd8;
		end else begin
			// marker bit, padding, then the bit length
			if (nv == FULL_BYTE) begin
				take_byte(d);
				take_byte(8'h80);
			end else begin
				keep = ~(8'hff >> nv);
				take_byte((d & keep) | (8'h80 >> nv));
			end
			bit_total = bit_total + 64'(nv);
			while (fill_pos != sha256_pkg::LEN_POS)
				take_byte(8'h00);
			for (int k = 7; k >= 0; k--)
				take_byte(bit_total[8*k +: 8]);
			for (int k = 0; k < 8; k++)
				digest_q.push_back('{
					word: typed ? typed_dg[255 - 32*k -: 32] : hash_st[k],
					idx:  3'(k),
					fin:  (3'(k) == LAST_WORD_IDX)
				});
			clear_hash();
			msgs_done++;
		end
	endtask

	// present one beat, hold it until the block takes it
	task automatic drive_beat(input logic [7:0] d, input logic [3:0] vb, input logic fin,
			input logic typed, input logic [255:0] typed_dg, input bit idle_on);
		if (idle_on && $urandom_range(0, 99) < 7) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		@(negedge clk);
		start      <= 1'b1;
		data_byte  <= d;
		valid_bits <= vb;
		last_item  <= fin;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		beats_sent++;
		predict_digest(d, vb, fin, typed, typed_dg);
	endtask

	// stop sending until every digest word has come out
	task automatic hold_for_digests();
		@(negedge clk);
		start <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
	endtask

	// random message: full bytes with junk counts, then a final beat
	task automatic send_message(input int n_bytes);
		logic [3:0] vb;
		bit idle_on;
		for (int i = 0; i <= n_bytes; i++) begin
			idle_on = !(beats_sent > DIR_ROWS + 60 && beats_sent < DIR_ROWS + 140);
			vb = 4'($urandom_range(0, 15));
			if (i == n_bytes && $urandom_range(0, 1) == 0)
				vb = FULL_BYTE;
			drive_beat(8'($urandom_range(0, 255)), vb, i == n_bytes, 1'b0, 256'd0, idle_on);
		end
		if (n_bytes > longest_msg)
			longest_msg = n_bytes;
	endtask

	// compare each digest beat with the oldest expectation
	always @(posedge clk) begin : check_digest
		digest_exp_t want;
		if (arst_n && done !== 1'b0) begin
			words_seen++;
			if (digest_q.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("unexpected digest beat: word %h index %0d last %b",
						digest_word, word_index, last_word);
			end else begin
				want = digest_q.pop_front();
				if (digest_word !== want.word || word_index !== want.idx
						|| last_word !== want.fin) begin
					bad_words++;
					if (bad_words <= 10)
						$display("digest mismatch: got %h/%0d/%b, want %h/%0d/%b",
							digest_word, word_index, last_word,
							want.word, want.idx, want.fin);
				end
			end
		end
	end

	initial begin : stimulus
		arst_n     = 1'b0;
		start      = 1'b0;
		data_byte  = '0;
		valid_bits = '0;
		last_item  = 1'b0;
		beats_sent = 0;
		msgs_done  = 0;
		words_seen = 0;
		bad_words  = 0;
		longest_msg = 0;
		for (int j = 0; j < 16; j++)
			win[j] = '0;
		clear_hash();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed beats
		for (int r = 0; r < DIR_ROWS; r++)
			drive_beat(dir_tab[r].d, dir_tab[r].vb, dir_tab[r].fin,
				dir_tab[r].typed, dir_tab[r].dg, 1'b1);
		hold_for_digests();

		// random messages, mostly short, some across the padding boundary
		while (beats_sent < DIR_ROWS + RAND_BEATS) begin
			if ($urandom_range(0, 99) < 75)
				msg_len = $urandom_range(0, 10);
			else if ($urandom_range(0, 99) < 80)
				msg_len = $urandom_range(50, 66);
			else
				msg_len = $urandom_range(115, 130);
			send_message(msg_len);
			if ($urandom_range(0, 9) == 0)
				hold_for_digests();
		end

		// drain and let the block settle
		@(negedge clk);
		start <= 1'b0;
		while (digest_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("covered %0d beats over %0d messages, longest random message %0d bytes",
			beats_sent, msgs_done, longest_msg);
		$display("compared %0d digest words, %0d mismatches", words_seen, bad_words);
		if (bad_words == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin : watchdog
		#(20_000_000);
		$display("timeout waiting for the digest block");
		$display("tb NOT OK");
		$finish;
	end

endmodule

[filelist.f]
rtl/sha256_pkg.sv
rtl/sha256_message_digest.sv
tb/sv/tb.sv
